// File: rtl/mrlb_pkg.sv
package mrlb_pkg;

  // Store geometry.
  localparam int STORE_DEPTH = 2048;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int POS_W       = $clog2(STORE_DEPTH + 1);

  // Port field widths.
  localparam int CMD_W  = 2;
  localparam int BYTE_W = 8;
  localparam int OFF_W  = 11;
  localparam int LEN_W  = 12;

  // Saturating message-end counter.
  localparam int COUNT_W = 12;
  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(4095);

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_END   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_WREAD,
    ST_WCHK,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_wr;
    logic accept;
    logic item_rd;
    logic exec;
    logic walk_rd;
    logic walk_chk;
    logic finish;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic walk_start;
    logic walk_stop;
    logic out_free;
  } dp_sts_t;

endpackage

// File: rtl/mrlb_ctrl.sv
module mrlb_ctrl import mrlb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.item_rd = 1'b1;
        state_nxt   = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.walk_start ? ST_WREAD : ST_FINISH;
      end
      ST_WREAD: begin
        cmd.walk_rd = 1'b1;
        state_nxt   = ST_WCHK;
      end
      ST_WCHK: begin
        cmd.walk_chk = 1'b1;
        state_nxt    = sts.walk_stop ? ST_FINISH : ST_WREAD;
      end
      ST_FINISH: begin
        cmd.finish = sts.out_free;
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule

// File: rtl/mrlb_dp.sv
module mrlb_dp import mrlb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  ctrl_cmd_t         cmd,
  output dp_sts_t           sts,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic [OFF_W-1:0]  in_read_offset,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_read_byte,
  output logic              out_offset_valid,
  output logic [LEN_W-1:0]  out_valid_length,
  output logic              out_has_wrapped
);

  localparam logic [POS_W-1:0]  DEPTH_P   = POS_W'(STORE_DEPTH);
  localparam logic [POS_W:0]    DEPTH_S   = (POS_W+1)'(STORE_DEPTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

  // Log store, one write port and one registered read port.
  logic [BYTE_W-1:0] log_mem [STORE_DEPTH];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [BYTE_W-1:0] mem_rdata_r;

  // Item and buffer state.
  logic [CMD_W-1:0]   cmd_r;
  logic [BYTE_W-1:0]  data_r;
  logic [OFF_W-1:0]   offset_r;
  logic [POS_W-1:0]   pos_r,      pos_nxt;
  logic               wrapped_r,  wrapped_nxt;
  logic [COUNT_W-1:0] count_r,    count_nxt;
  logic [ADDR_W-1:0]  ptr_r,      ptr_nxt;
  logic [ADDR_W-1:0]  steps_r,    steps_nxt;
  logic               rd_ok_r,    rd_ok_nxt;
  logic [BYTE_W-1:0]  rbyte_r,    rbyte_nxt;

  // Result register.
  logic               out_valid_r,  out_valid_nxt;
  logic [BYTE_W-1:0]  out_byte_r;
  logic               out_ok_r;
  logic [LEN_W-1:0]   out_len_r;
  logic               out_wrap_r;

  // Helpers.
  logic [POS_W-1:0]   len;
  logic [POS_W:0]     idx_sum;
  logic [POS_W:0]     idx_mod;
  logic [ADDR_W-1:0]  read_idx;
  logic [COUNT_W-1:0] count_inc;
  logic [COUNT_W-1:0] count_dec;
  logic [POS_W-1:0]   pos_inc;
  logic               byte_zero;
  logic               end_new;

  assign len       = wrapped_r ? DEPTH_P : pos_r;
  assign idx_sum   = {1'b0, pos_r} + (POS_W+1)'(offset_r);
  assign idx_mod   = (idx_sum >= DEPTH_S) ? (idx_sum - DEPTH_S) : idx_sum;
  assign read_idx  = wrapped_r ? ADDR_W'(idx_mod) : ADDR_W'(offset_r);
  assign count_inc = (count_r == COUNT_MAX) ? count_r : count_r + COUNT_W'(1);
  assign count_dec = (count_r == '0) ? count_r : count_r - COUNT_W'(1);
  assign pos_inc   = pos_r + POS_W'(1);
  assign byte_zero = (mem_rdata_r == '0);
  assign end_new   = (cmd_r == CMD_END) && !byte_zero;

  // Status toward the controller.
  always_comb begin
    sts.clr_last   = (ptr_r == LAST_ADDR);
    sts.walk_start = end_new && (wrapped_r || (pos_inc == DEPTH_P))
                     && (count_inc != COUNT_W'(1));
    sts.walk_stop  = byte_zero || (steps_r == LAST_ADDR);
    sts.out_free   = !out_valid_r || out_ready;
  end

  // Next-state logic for the buffer state and memory controls.
  always_comb begin
    pos_nxt     = pos_r;
    wrapped_nxt = wrapped_r;
    count_nxt   = count_r;
    ptr_nxt     = ptr_r;
    steps_nxt   = steps_r;
    rd_ok_nxt   = rd_ok_r;
    rbyte_nxt   = rbyte_r;
    mem_we      = 1'b0;
    mem_waddr   = ptr_r;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = pos_r[ADDR_W-1:0];

    // Power-on clearing pass over the whole store.
    if (cmd.clr_wr) begin
      mem_we  = 1'b1;
      ptr_nxt = (ptr_r == LAST_ADDR) ? '0 : ptr_r + ADDR_W'(1);
    end

    // Lazy wrap when a write or an end arrives at the top of the store.
    if (cmd.accept && (in_command == CMD_WRITE || in_command == CMD_END)
        && pos_r == DEPTH_P) begin
      pos_nxt     = '0;
      wrapped_nxt = 1'b1;
    end

    // Fetch the byte that the item needs.
    if (cmd.item_rd) begin
      mem_re    = 1'b1;
      mem_raddr = (cmd_r == CMD_READ) ? read_idx : pos_r[ADDR_W-1:0];
      rd_ok_nxt = (cmd_r == CMD_READ) && (32'(offset_r) < 32'(len));
    end

    // Apply the item.
    if (cmd.exec) begin
      case (cmd_r)
        CMD_WRITE: begin
          mem_we    = 1'b1;
          mem_waddr = pos_r[ADDR_W-1:0];
          mem_wdata = data_r;
          pos_nxt   = pos_inc;
          if (wrapped_r && byte_zero) begin
            count_nxt = count_dec;
          end
        end
        CMD_END: begin
          pos_nxt = pos_inc;
          if (byte_zero) begin
            if (!wrapped_r) begin
              count_nxt = count_inc;
            end
          end else begin
            mem_we    = 1'b1;
            mem_waddr = pos_r[ADDR_W-1:0];
            count_nxt = count_inc;
            if (pos_inc == DEPTH_P) begin
              pos_nxt     = '0;
              wrapped_nxt = 1'b1;
            end
          end
          ptr_nxt   = pos_nxt[ADDR_W-1:0];
          steps_nxt = '0;
        end
        CMD_READ: begin
          rbyte_nxt = mem_rdata_r;
        end
        default: begin
        end
      endcase
    end

    // Clearing walk over the oldest message.
    if (cmd.walk_rd) begin
      mem_re    = 1'b1;
      mem_raddr = ptr_r;
    end
    if (cmd.walk_chk && !byte_zero) begin
      mem_we    = 1'b1;
      mem_waddr = ptr_r;
      count_nxt = count_inc;
      ptr_nxt   = (ptr_r == LAST_ADDR) ? '0 : ptr_r + ADDR_W'(1);
      steps_nxt = steps_r + ADDR_W'(1);
    end
  end

  // Result register: loaded at the end of an item, freed by a transfer.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      wrapped_r   <= 1'b0;
      count_r     <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      wrapped_r   <= wrapped_nxt;
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    steps_r <= steps_nxt;
    rd_ok_r <= rd_ok_nxt;
    rbyte_r <= rbyte_nxt;
    if (cmd.accept) begin
      cmd_r    <= in_command;
      data_r   <= in_data_byte;
      offset_r <= in_read_offset;
    end
    if (cmd.finish) begin
      out_byte_r <= rd_ok_r ? rbyte_r : '0;
      out_ok_r   <= rd_ok_r;
      out_len_r  <= LEN_W'(len);
      out_wrap_r <= wrapped_r;
    end
  end

  // Store write and registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      log_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= log_mem[mem_raddr];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_byte    = out_byte_r;
  assign out_offset_valid = out_ok_r;
  assign out_valid_length = out_len_r;
  assign out_has_wrapped  = out_wrap_r;

endmodule

// File: rtl/message_ring_log_buffer_top.sv
// Channel | Handshake            | Payload
// in      | in_valid / in_ready  | in_command, in_data_byte, in_read_offset
// out     | out_valid/ out_ready | out_read_byte, out_offset_valid,
//         |                      | out_valid_length, out_has_wrapped
//
// Each item passes through transfer, store read, update and result load.
// An end of message that clears the oldest message adds a store read and a
// check for each byte visited by the clearing walk. After reset a clearing
// pass writes zero to all STORE_DEPTH entries with in_ready low.
// The result sits in an output register; a new item is taken while it waits,
// and the next item holds in its last cycle until that register is free.
module message_ring_log_buffer_top import mrlb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic [OFF_W-1:0]  in_read_offset,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_read_byte,
  output logic              out_offset_valid,
  output logic [LEN_W-1:0]  out_valid_length,
  output logic              out_has_wrapped
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // Sequencer.
  mrlb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Store, pointers, counter and result register.
  mrlb_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_command       (in_command),
    .in_data_byte     (in_data_byte),
    .in_read_offset   (in_read_offset),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_read_byte    (out_read_byte),
    .out_offset_valid (out_offset_valid),
    .out_valid_length (out_valid_length),
    .out_has_wrapped  (out_has_wrapped)
  );

endmodule

// File: rtl/mrlb_checker.sv
module mrlb_checker import mrlb_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] out_read_byte,
  input logic              out_offset_valid,
  input logic [LEN_W-1:0]  out_valid_length,
  input logic              out_has_wrapped
);

  // A stalled result keeps its transfer pending with the same data.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_byte)
    && $stable(out_valid_length))
    else $error("stalled result changed");

  // A byte outside the valid range reads as zero.
  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_offset_valid |-> out_read_byte == '0)
    else $error("read byte not zero without a valid offset");

  // Once wrapped, the whole store counts as held data.
  a_wrap_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_wrapped |-> out_valid_length == LEN_W'(STORE_DEPTH))
    else $error("wrapped buffer reports a short length");

  // The held length never exceeds the store.
  a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_valid_length <= LEN_W'(STORE_DEPTH))
    else $error("length beyond store depth");

  // One item at a time: the input closes right after a transfer.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in progress");

endmodule

bind message_ring_log_buffer_top mrlb_checker u_mrlb_checker (.*);
